// ----- rtl/core/rpn_postfix_evaluator_macros.svh -----
// Assertion helpers for the postfix evaluator.
`ifndef RPN_POSTFIX_EVALUATOR_MACROS_SVH
`define RPN_POSTFIX_EVALUATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RPN_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RPN_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/rpn_pkg.sv -----
package rpn_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS = 48;
    localparam int DSTEP_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        REQ_NUM = 2'd0,
        REQ_OP  = 2'd1,
        REQ_END = 2'd2,
        REQ_NOP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3
    } t_op_known;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_RIGHT = 3'd1,
        ST_NO_LEFT  = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_BAD_OP   = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_END_BAD  = 3'd6
    } t_status;

    // stack chain control, decoded separately for cell 0 and for the cells below it
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2,
        SH_POP2 = 2'd3
    } t_shift;

    typedef struct packed {
        t_shift       shift;
        logic [31:0]  top_in;
    } t_stk_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 64'h8000_0000) r = 32'h8000_0000;
            else r = 32'(-mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
            else r = mag[31:0];
        end
        return r;
    endfunction
endpackage

// ----- rtl/core/rpn_cell.sv -----
// One stack slot. Cell 0 is the top; data moves down on push, up on pop.
module rpn_cell
    import rpn_pkg::*;
(
    input  logic        i_clk,
    input  t_shift      i_shift,
    input  logic [31:0] i_from_up,   // cell above (or new top for cell 0)
    input  logic [31:0] i_from_dn1,  // next cell below
    input  logic [31:0] i_from_dn2,  // two cells below
    output logic [31:0] o_data
);
    logic [31:0] r_data, n_data;

    always_comb begin
        case (i_shift)
            SH_PUSH: n_data = i_from_up;
            SH_POP:  n_data = i_from_dn1;
            SH_POP2: n_data = i_from_dn2;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// ----- rtl/core/rpn_stack.sv -----
// Chain of cells. POP2 with a new top: cell0 gets top_in, others take from the cell below.
module rpn_stack
    import rpn_pkg::*;
(
    input  logic        i_clk,
    input  t_stk_ctl    i_ctl,
    output logic [31:0] o_top,
    output logic [31:0] o_next
);
    logic [31:0] w_d [STACK_DEPTH+2];
    t_shift      w_sh0;

    assign w_d[STACK_DEPTH]   = '0;
    assign w_d[STACK_DEPTH+1] = '0;

    // cell 0 loads the new value on push or on a binary-op replace
    always_comb begin
        case (i_ctl.shift)
            SH_POP2: w_sh0 = SH_PUSH;
            default: w_sh0 = i_ctl.shift;
        endcase
    end

    // POP2 on cells below 0 means: take from one below the removed pair
    // (net shift of one).
    rpn_cell u_c0 (
        .i_clk(i_clk), .i_shift(w_sh0), .i_from_up(i_ctl.top_in),
        .i_from_dn1(w_d[1]), .i_from_dn2(w_d[2]), .o_data(w_d[0])
    );

    t_shift w_shn;
    always_comb begin
        case (i_ctl.shift)
            SH_POP2: w_shn = SH_POP;
            default: w_shn = i_ctl.shift;
        endcase
    end

    for (genvar g = 1; g < STACK_DEPTH; g++) begin : g_cell
        logic [31:0] w_up;
        assign w_up = w_d[g-1];
        rpn_cell u_c (
            .i_clk(i_clk), .i_shift(w_shn), .i_from_up(w_up),
            .i_from_dn1(w_d[g+1]),
            .i_from_dn2(w_d[g+2]), .o_data(w_d[g])
        );
    end

    assign o_top  = w_d[0];
    assign o_next = w_d[1];
endmodule

// ----- rtl/core/rpn_postfix_evaluator.sv -----
// Postfix evaluator: one token word per input handshake, one status word per
// output handshake (status, result_value, result_valid) for every token.
// Input channel i_valid/o_ready carries req_type, value and op_code.
// Output channel o_valid/i_ready carries the result word.
// Operands live in a chain of 16 shift cells; cell 0 is the stack top.
// Number, end, add, sub and bad-op tokens go from accept through the execute
// state straight to the result; multiply adds the multiply stage, then the
// write-back; divide adds the multiply stage, a 48-step restoring divider
// (one quotient bit per cycle) and the write-back. One token is in flight at
// a time; o_ready rises the cycle after its result is taken, so no new token
// is accepted before the receiver takes the last result word.
// Reset (synchronous, active low) empties the stack and drops any pending
// result. While the receiver holds i_ready low the result word stays
// unchanged and no new token is accepted.
// Errors report their status and empty the stack.
`include "rpn_postfix_evaluator_macros.svh"
module rpn_postfix_evaluator
    import rpn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic signed [31:0] i_value,
    input  logic [2:0]  i_op_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic signed [31:0] o_result_value,
    output logic        o_result_valid
);
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]  r_req;
    logic [31:0] r_val;
    logic [2:0]  r_op;
    logic [2:0]  r_st, n_st;
    logic [31:0] r_res, n_res;
    logic        r_rv, n_rv;
    t_stk_ctl    w_ctl;
    logic [31:0] w_top, w_next;

    // operand magnitudes and sign held across multiply / divide
    logic [31:0] r_ma, r_mb;    // |left|, |right| (fits 32 bits unsigned)
    logic        r_neg;
    logic [63:0] r_prod;
    logic [47:0] r_quo;         // dividend bits shift out, quotient in
    logic [32:0] r_rem;
    logic [DSTEP_W-1:0] r_dstep;
    logic [63:0] w_sum;

    rpn_stack u_stack (.i_clk(i_clk), .i_ctl(w_ctl), .o_top(w_top), .o_next(w_next));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_result_value = r_res;
    assign o_result_valid = r_rv;

    logic [32:0] w_trial;
    assign w_trial = {r_rem[31:0], r_quo[47]} - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st  <= n_st;
        r_res <= n_res;
        r_rv  <= n_rv;
        if (o_ready && i_valid) begin
            r_req <= i_req_type;
            r_val <= i_value;
            r_op  <= i_op_code;
        end
        if (r_state == S_EXEC) begin
            r_ma  <= w_next[31] ? 32'(-w_next) : w_next;
            r_mb  <= w_top[31]  ? 32'(-w_top)  : w_top;
            r_neg <= w_next[31] ^ w_top[31];
            r_dstep <= '0;
            r_rem <= '0;
        end
        if (r_state == S_MUL) r_prod <= 64'(r_ma) * 64'(r_mb);
        if (r_state == S_MUL && r_op == OP_DIV) r_quo <= {r_ma, 16'd0};
        if (r_state == S_DIV) begin
            r_dstep <= r_dstep + 1'b1;
            if (!w_trial[32]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[47]};
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_st    = r_st;
        n_res   = r_res;
        n_rv    = r_rv;
        w_ctl.shift  = SH_HOLD;
        w_ctl.top_in = r_val;
        w_sum = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_st = ST_OK; n_res = '0; n_rv = 1'b0;
                n_state = S_OUT;
                case (r_req)
                    REQ_NUM: begin
                        if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                            n_st = ST_OVERFLOW; n_cnt = '0;
                        end else begin
                            w_ctl.shift = SH_PUSH;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    REQ_OP: begin
                        if (r_cnt == '0) begin
                            n_st = ST_NO_RIGHT;
                        end else if (r_cnt == CNT_W'(1)) begin
                            n_st = ST_NO_LEFT; n_cnt = '0;
                        end else begin
                            case (r_op)
                                OP_ADD, OP_SUB: begin
                                    if (r_op == OP_ADD)
                                        w_sum = 64'(signed'(w_next)) + 64'(signed'(w_top));
                                    else
                                        w_sum = 64'(signed'(w_next)) - 64'(signed'(w_top));
                                    w_ctl.shift = SH_POP2;
                                    w_ctl.top_in = sat_mag(w_sum[63] ? -w_sum : w_sum,
                                                           w_sum[63]);
                                    n_cnt = r_cnt - 1'b1;
                                end
                                OP_MUL: n_state = S_MUL;
                                OP_DIV: begin
                                    if (w_top == '0) begin
                                        n_st = ST_DIV_ZERO; n_cnt = '0;
                                    end else n_state = S_MUL;
                                end
                                default: begin
                                    n_st = ST_BAD_OP; n_cnt = '0;
                                end
                            endcase
                        end
                    end
                    REQ_END: begin
                        n_cnt = '0;
                        if (r_cnt != CNT_W'(1)) n_st = ST_END_BAD;
                        else begin
                            n_res = w_top; n_rv = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_MUL: n_state = (r_op == OP_DIV) ? S_DIV : S_FIN;
            S_DIV: if (r_dstep == DSTEP_W'(DIV_STEPS - 1)) n_state = S_FIN;
            S_FIN: begin
                w_ctl.shift = SH_POP2;
                w_ctl.top_in = (r_op == OP_DIV) ? sat_mag({16'd0, r_quo}, r_neg)
                                                : sat_mag({16'd0, r_prod[63:16]}, r_neg);
                n_cnt = r_cnt - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    `RPN_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(STACK_DEPTH), "stack count out of range")
    `RPN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_result_value), "result changed while stalled")
    `RPN_ASSERT_IMPL(a_rv_ok, i_clk, i_rst_n, o_valid && o_result_valid, o_status == ST_OK, "valid result with error status")
    `RPN_ASSERT_NEXT(a_err_clear, i_clk, i_rst_n, r_state == S_EXEC && n_st != ST_OK, r_cnt == '0, "error left stack entries")
endmodule

// ----- dv/rpn_postfix_evaluator_tb.sv -----
module rpn_postfix_evaluator_tb;
    import rpn_pkg::*;

    // token word fields and result word fields
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [2:0]  op;
    } token_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] value;
        logic        valid;
    } verdict_t;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic signed [31:0] i_value;
    logic [2:0]  i_op_code;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic signed [31:0] o_result_value;
    logic        o_result_valid;

    rpn_postfix_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_op_code      (i_op_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_result_valid (o_result_valid)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: our own copy of the operand stack.
    logic signed [31:0] stack_mem [STACK_DEPTH];
    int unsigned        depth_now;
    verdict_t           pending_results [$];

    int unsigned errors;
    int unsigned tokens_sent;
    int unsigned words_checked;
    int unsigned ends_ok;
    int unsigned idle_cycles;
    bit          hold_off;     // long receiver stall request
    bit          rx_jitter;    // random receiver stalls enabled
    bit          tx_jitter;    // random sender gaps enabled

    function automatic logic [31:0] clamp_mag(logic [63:0] mag, logic neg);
        if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [31:0] clamp_sum(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Evaluate one token against the model stack; returns the expected word.
    function automatic verdict_t evaluate_token(token_t t);
        verdict_t r;
        logic signed [31:0] rhs, lhs, acc;
        logic neg;
        r = '{ST_OK, 32'd0, 1'b0};
        case (t.kind)
            REQ_NUM: begin
                if (depth_now >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                    depth_now = 0;
                end else begin
                    stack_mem[depth_now] = t.value;
                    depth_now++;
                end
            end
            REQ_OP: begin
                if (depth_now == 0) begin
                    r.status = ST_NO_RIGHT;
                end else if (depth_now == 1) begin
                    r.status = ST_NO_LEFT;
                    depth_now = 0;
                end else begin
                    rhs = stack_mem[depth_now-1];
                    lhs = stack_mem[depth_now-2];
                    depth_now -= 2;
                    acc = 0;
                    neg = lhs[31] ^ rhs[31];
                    case (t.op)
                        OP_ADD: acc = clamp_sum(64'(lhs) + 64'(rhs));
                        OP_SUB: acc = clamp_sum(64'(lhs) - 64'(rhs));
                        OP_MUL: acc = clamp_mag((abs64(lhs) * abs64(rhs)) >> 16, neg);
                        OP_DIV: begin
                            if (rhs == 0) r.status = ST_DIV_ZERO;
                            else acc = clamp_mag((abs64(lhs) << 16) / abs64(rhs), neg);
                        end
                        default: r.status = ST_BAD_OP;
                    endcase
                    if (r.status != ST_OK) depth_now = 0;
                    else begin
                        stack_mem[depth_now] = acc;
                        depth_now++;
                    end
                end
            end
            REQ_END: begin
                if (depth_now != 1) r.status = ST_END_BAD;
                else begin
                    r.value = stack_mem[0];
                    r.valid = 1'b1;
                end
                depth_now = 0;
            end
            default: ;  // unused kind: no state change, all-zero word
        endcase
        return r;
    endfunction

    // Offer one token; hold it until accepted. Predicts on acceptance.
    task automatic send_token(token_t t);
        int gap;
        if (tx_jitter && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= t.kind;
        i_value    <= t.value;
        i_op_code  <= t.op;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(evaluate_token(t));
        tokens_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
    endtask

    task automatic push_num(logic [31:0] v);
        send_token('{REQ_NUM, v, 3'($urandom)});
    endtask

    task automatic push_op(logic [2:0] op);
        send_token('{REQ_OP, $urandom, op});
    endtask

    task automatic push_end();
        send_token('{REQ_END, $urandom, 3'($urandom)});
    endtask

    // Receiver: random stall pattern, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else if (rx_jitter) i_ready <= ($urandom_range(0, 2) != 0);
        else i_ready <= 1'b1;
    end

    // Result checker.
    always @(posedge i_clk) begin
        verdict_t w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                w = pending_results.pop_front();
                words_checked++;
                if (o_status !== w.status) begin
                    $error("status: expected %0d actual %0d", w.status, o_status);
                    errors++;
                end
                if (o_result_value !== w.value) begin
                    $error("result_value: expected %h actual %h", w.value, o_result_value);
                    errors++;
                end
                if (o_result_valid !== w.valid) begin
                    $error("result_valid: expected %0d actual %0d", w.valid,
                           o_result_valid);
                    errors++;
                end
                if (w.valid) ends_ok++;
            end
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
            2: return {32{1'b1}} ^ $urandom_range(0, 3);
            3: return 32'(($urandom_range(0, 16) - 8) <<< 16);
            4: return 32'($urandom_range(0, 3));
            default: return 32'h7FFF_FFFF ^ ($urandom & 32'h1);
        endcase
    endfunction

    // Directed: field extremes, each operation, each error case.
    task automatic test_directed();
        int i;
        push_num(32'h7FFF_FFFF); push_num(32'h0000_0001); push_op(OP_ADD); push_end();
        push_num(32'h8000_0000); push_num(32'h0000_0001); push_op(OP_SUB); push_end();
        push_num(32'h8000_0000); push_num(32'hFFFF_0000); push_op(OP_MUL); push_end();
        push_num(32'hFFFF_FFFF); push_num(32'h0000_0100); push_op(OP_DIV); push_end();
        push_num(32'h0003_0000); push_num(32'h0000_0000); push_op(OP_DIV);
        push_op(OP_ADD);                       // missing right operand
        push_num(32'h1); push_op(3'd7);        // missing left, bad op code ignored
        push_num(32'h1); push_num(32'h2); push_op(3'd4); // unsupported op
        push_end();                            // end on empty stack
        push_num(32'h5); push_num(32'h6); push_end();    // leftover at end
        send_token('{REQ_NOP, 32'hFFFF_FFFF, 3'd7});
        for (i = 0; i <= STACK_DEPTH; i++) push_num(32'(i));  // overflow
        push_end();
    endtask

    // Random well-formed expressions with some noise and broken sequences.
    task automatic test_random_expressions(int unsigned budget);
        int unsigned start, need, i;
        start = tokens_sent;
        while (tokens_sent - start < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                send_token('{2'($urandom), $urandom, 3'($urandom)});
                continue;
            end
            need = $urandom_range(1, 6);
            push_num(rand_q());
            for (i = 1; i < need; i++) begin
                push_num(rand_q());
                if ($urandom_range(0, 1)) push_op(3'($urandom_range(0, 3)));
            end
            while (depth_now > 1) push_op($urandom_range(0, 15) == 0 ?
                                          3'($urandom) : 3'($urandom_range(0, 3)));
            push_end();
        end
    endtask

    // Long receiver stall while tokens keep arriving.
    task automatic test_backpressure();
        int unsigned i;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 8; i++) push_num(rand_q());
        join
        push_end();
    endtask

    initial begin
        int unsigned waited;
        errors = 0; tokens_sent = 0; words_checked = 0; ends_ok = 0;
        idle_cycles = 0; depth_now = 0;
        hold_off = 1'b0; rx_jitter = 1'b0; tx_jitter = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_req_type = REQ_NOP; i_value = '0; i_op_code = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        rx_jitter = 1'b1;
        tx_jitter = 1'b1;
        test_random_expressions(200);
        test_backpressure();
        rx_jitter = 1'b0;
        tx_jitter = 1'b0;
        test_random_expressions(60);
        rx_jitter = 1'b1;
        tx_jitter = 1'b1;
        test_random_expressions(140);
        go_idle();

        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d tokens, %0d result words, %0d good expressions,",
                 tokens_sent, words_checked, ends_ok);
        $display("with random stalls on both sides and a long receiver hold-off.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rpn_pkg.sv
rtl/core/rpn_cell.sv
rtl/core/rpn_stack.sv
rtl/core/rpn_postfix_evaluator.sv
dv/rpn_postfix_evaluator_tb.sv
